// ===== rtl/pdau_pkg.sv =====
// Shared types and constants of the pixel disturbance alert update block.
// Used by the top level and by the state RAM sizing; no dependencies.
package pdau_pkg;

    localparam int NUM_PIXELS_DEF = 1048576;
    localparam int IDX_W          = 24;
    localparam int CFG_W          = 15;

    // status codes
    localparam logic [7:0] ST_NONE     = 8'd0;
    localparam logic [7:0] ST_LO_FIRST = 8'd1;
    localparam logic [7:0] ST_LO_PROV  = 8'd2;
    localparam logic [7:0] ST_LO_CONF  = 8'd3;
    localparam logic [7:0] ST_HI_FIRST = 8'd4;
    localparam logic [7:0] ST_HI_PROV  = 8'd5;
    localparam logic [7:0] ST_HI_CONF  = 8'd6;
    localparam logic [7:0] ST_LO_DONE  = 8'd7;
    localparam logic [7:0] ST_HI_DONE  = 8'd8;
    localparam logic [7:0] ST_NODATA   = 8'd255;

    localparam int          EXPIRY_DAYS = 365;
    localparam logic [7:0]  CNT_HOLD    = 8'd253;
    localparam logic [7:0]  CNT_MAX     = 8'd254;
    localparam logic [15:0] CONF_CAP    = 16'd32000;
    localparam logic [15:0] CONF_MIN    = 16'd400;
    localparam logic [7:0]  PCT_RESET   = 8'd200;
    localparam logic [7:0]  PCT_FULL    = 8'd100;
    localparam logic [7:0]  PCT_ZERO    = 8'd0;
    localparam logic [14:0] ANOM_CLIP   = 15'd100;

    typedef enum logic [1:0] {
        CFG_CUR_DATE  = 2'd0,
        CFG_LOW_THR   = 2'd1,
        CFG_HIGH_THR  = 2'd2,
        CFG_QUIET_LIM = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic               req_type;
        logic [23:0]        pixel_index;
        logic signed [15:0] anomaly;
        logic [7:0]         load_status;
        logic signed [15:0] load_max;
        logic signed [15:0] load_confidence;
        logic signed [15:0] load_start_date;
        logic [7:0]         load_count;
        logic [7:0]         load_percent;
        logic signed [15:0] load_duration;
        logic signed [15:0] load_last_obs;
    } t_req;

    typedef struct packed {
        logic [23:0]        out_pixel_index;
        logic [7:0]         out_status;
        logic signed [15:0] out_max;
        logic signed [15:0] out_confidence;
        logic signed [15:0] out_start_date;
        logic [7:0]         out_count;
        logic [7:0]         out_percent;
        logic signed [15:0] out_duration;
        logic signed [15:0] out_last_obs;
    } t_res;

    // one RAM word: the whole state of a pixel
    typedef struct packed {
        logic [7:0]         status;
        logic signed [15:0] max;
        logic signed [15:0] conf;
        logic signed [15:0] start;
        logic [7:0]         count;
        logic [7:0]         pct;
        logic signed [15:0] dur;
        logic signed [15:0] last;
    } t_state;

    // every field resets to all ones (255 or -1)
    localparam t_state STATE_RST = '1;

endpackage

// ===== rtl/pdau_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module pdau_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pdau_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, QW stages.
// Needs num < den * 2**QW. No dependencies.
module pdau_div #(
    parameter int NW = 15,
    parameter int DW = 7,
    parameter int QW = 15
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    localparam int WW = (NW > DW + QW) ? NW : DW + QW;

    logic [WW-1:0] r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_quo [QW];

    for (genvar s = 0; s < QW; s++) begin : g_st
        localparam int J = QW - 1 - s;
        logic [WW-1:0] rem_in;
        logic [WW-1:0] trial;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic          take;

        if (s == 0) begin : g_first
            assign rem_in = WW'(i_num);
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign den_in = r_den[s-1];
            assign quo_in = r_quo[s-1];
        end

        assign trial = WW'(den_in) << J;
        assign take  = (rem_in >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= take ? (rem_in - trial) : rem_in;
                r_den[s] <= den_in;
                r_quo[s] <= quo_in | (take ? (QW'(1) << J) : '0);
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

// ===== rtl/pixel_disturbance_alert_update.sv =====
// Pixel disturbance alert update: per-pixel state in one RAM, read-modify-write pipeline.
// One word per cycle, unless a pixel hazard or an output stall holds the input off.
// A word whose pixel is still in the pipeline waits until that pixel is written back;
// the output register stalls the whole pipeline when not taken.
// After reset every address of the state RAM is swept to the no-data pattern;
// input is held off meanwhile, configuration writes are taken.
module pixel_disturbance_alert_update #(
    parameter int NUM_PIXELS = pdau_pkg::NUM_PIXELS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pdau_pkg::t_req    i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output pdau_pkg::t_res    o_out_data,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [pdau_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int AW   = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
    localparam int D1   = 15;
    localparam int D2   = 7;
    localparam int D3   = 15;
    localparam int SB   = D1 + 1;
    localparam int SC   = SB + 1;
    localparam int SD   = SC + 1;
    localparam int SE   = SD + 1;
    localparam int SP   = SB + D2 + 1;
    localparam int LAST = SE + D3;

    typedef struct packed {
        logic [23:0]      idx;
        logic             ok;
        logic             upd;
        logic             hit;
        logic [14:0]      anom;
        logic [6:0]       cac;
        pdau_pkg::t_state s;
        logic [7:0]       pcnt;
        logic [14:0]      d1num;
        logic [6:0]       d1den;
        logic             pdiv;
        logic [14:0]      d2num;
        logic [14:0]      d2den;
        logic             cf_div;
        logic [14:0]      n;
        logic [15:0]      pc2;
        logic [15:0]      cn2;
        logic [29:0]      p1;
        logic [22:0]      p2;
        logic [30:0]      den;
        logic [46:0]      num;
        logic [45:0]      capd;
        logic             over;
    } t_work;

    // configuration
    logic [14:0] r_cur_date, r_low_thr, r_high_thr, r_quiet_lim;

    // pipeline
    pdau_pkg::t_req   r_in;
    logic             r_in_v;
    t_work            r_w [LAST+1];
    t_work            n_w [LAST+1];
    logic [LAST:0]    r_v;
    pdau_pkg::t_res   r_out;
    pdau_pkg::t_res   n_out;
    logic             r_ovld;
    pdau_pkg::t_state fin;

    // clearing sweep
    logic             r_clearing;
    logic [AW-1:0]    r_clr_addr;

    logic             adv, accept, hazard, wr_en;
    logic [AW-1:0]    wr_addr;
    pdau_pkg::t_state wr_data, rd_data;
    logic [14:0]      q1;
    logic [6:0]       q2;
    logic [14:0]      q3;

    function automatic pdau_pkg::t_state f_clear(pdau_pkg::t_state s, logic [7:0] pval);
        pdau_pkg::t_state o;
        o        = s;
        o.status = pdau_pkg::ST_NONE;
        o.pct    = pval;
        o.count  = '0;
        o.max    = '0;
        o.conf   = '0;
        o.start  = '0;
        o.dur    = '0;
        return o;
    endfunction

    function automatic t_work f_pre(pdau_pkg::t_req rq, logic rq_ok, pdau_pkg::t_state rd,
                                    logic [14:0] cd, logic [14:0] lo_thr);
        t_work             w;
        logic signed [17:0] age;
        logic              clr;
        w      = '0;
        w.idx  = rq.pixel_index;
        w.ok   = rq_ok;
        w.s    = rq_ok ? rd : pdau_pkg::STATE_RST;
        w.upd  = !rq.req_type && !rq.anomaly[15];
        w.anom = rq.anomaly[14:0];
        w.cac  = (rq.anomaly[14:0] > pdau_pkg::ANOM_CLIP) ? pdau_pkg::ANOM_CLIP[6:0]
                                                          : rq.anomaly[6:0];
        w.hit  = w.upd && (rq.anomaly[14:0] >= lo_thr);
        if (rq.req_type) begin
            w.s.status = rq.load_status;
            w.s.max    = rq.load_max;
            w.s.conf   = rq.load_confidence;
            w.s.start  = rq.load_start_date;
            w.s.count  = rq.load_count;
            w.s.pct    = rq.load_percent;
            w.s.dur    = rq.load_duration;
            w.s.last   = rq.load_last_obs;
        end
        // expiry, or a new hit on a finished alert or a no-data pixel
        age = $signed({3'b000, cd}) - 18'(w.s.start);
        clr = w.upd && ((age > $signed(18'(pdau_pkg::EXPIRY_DAYS)))
                        || ((w.s.status > pdau_pkg::ST_HI_CONF) && w.hit));
        if (clr) begin
            w.s = f_clear(w.s, pdau_pkg::PCT_RESET);
        end
        w.pcnt = w.s.count;
        if ((w.s.pct != pdau_pkg::PCT_ZERO) && (w.s.pct <= pdau_pkg::PCT_FULL)) begin
            w.d1num = (15'(pdau_pkg::PCT_FULL) - 15'(w.s.pct)) * 15'(w.s.count);
            w.d1den = w.s.pct[6:0];
        end else begin
            w.d1num = '0;
            w.d1den = 7'd1;
        end
        return w;
    endfunction

    function automatic t_work f_stage_b(t_work w, logic [14:0] prevno, logic [14:0] cd);
        t_work      o;
        logic [7:0] cnn;
        o        = w;
        o.pdiv   = 1'b0;
        o.cf_div = 1'b0;
        cnn      = w.s.count + 8'd1;
        if (w.upd) begin
            if (w.hit) begin
                if ((w.s.status == pdau_pkg::ST_NONE) || (w.s.status == pdau_pkg::ST_NODATA)) begin
                    o.s.start = $signed({1'b0, cd});
                    o.s.max   = $signed({1'b0, w.anom});
                    o.s.pct   = pdau_pkg::PCT_FULL;
                    o.s.count = 8'd1;
                end else begin
                    if ($signed({1'b0, w.anom}) > w.s.max) begin
                        o.s.max = $signed({1'b0, w.anom});
                    end
                    if (w.s.count < pdau_pkg::CNT_HOLD) begin
                        o.s.count = cnn;
                        o.pdiv    = 1'b1;
                        o.d2num   = 15'(cnn) * 15'(pdau_pkg::PCT_FULL);
                        o.d2den   = 15'(cnn) + prevno;
                    end
                end
                o.s.dur = $signed(16'({1'b0, cd}) - o.s.start + 16'd1);
            end else begin
                if ((w.s.pct != pdau_pkg::PCT_ZERO) && (w.s.pct <= pdau_pkg::PCT_FULL)
                    && (w.s.count < pdau_pkg::CNT_MAX)) begin
                    o.pdiv  = 1'b1;
                    o.d2num = 15'(w.s.count) * 15'(pdau_pkg::PCT_FULL);
                    o.d2den = 15'(w.pcnt) + prevno + 15'd1;
                end
                if (w.s.status == pdau_pkg::ST_NODATA) begin
                    o.s    = f_clear(o.s, pdau_pkg::PCT_RESET);
                    o.pdiv = 1'b0;
                end
            end
            if ((o.s.conf > 16'sd0) && (o.s.status <= pdau_pkg::ST_HI_CONF)) begin
                if (w.pcnt == 8'd0) begin
                    o.s.conf = pdau_pkg::CONF_CAP;
                end else begin
                    o.cf_div = 1'b1;
                end
            end else if ((o.s.status == pdau_pkg::ST_NONE)
                         || (o.s.status == pdau_pkg::ST_NODATA)) begin
                o.s.conf = w.hit ? $signed({9'b0, w.cac}) : 16'sd0;
            end
            o.n   = 15'(w.pcnt) + prevno;
            o.pc2 = 16'(w.pcnt) * 16'(w.pcnt);
            o.cn2 = 16'(o.s.count) * 16'(o.s.count);
        end
        return o;
    endfunction

    function automatic pdau_pkg::t_state f_fin(t_work w, logic [14:0] quo, logic [14:0] cd,
                                               logic [14:0] lo_thr, logic [14:0] hi_thr,
                                               logic [14:0] lim);
        pdau_pkg::t_state   s;
        logic signed [15:0] lad;
        logic signed [17:0] gap;
        logic               ends;
        s = w.s;
        if (w.upd) begin
            if (w.cf_div) begin
                s.conf = w.over ? pdau_pkg::CONF_CAP : {1'b0, quo};
            end
            // date of the last anomaly
            lad  = s.start + s.dur - 16'sd1;
            gap  = $signed({3'b000, cd}) - 18'(lad);
            ends = ((s.last > lad) && !w.hit)
                   || ((gap >= $signed({3'b000, lim})) && (lad > 16'sd0))
                   || ((s.dur == 16'sd1) && !w.hit);
            if ((s.status <= pdau_pkg::ST_HI_CONF) || (s.status == pdau_pkg::ST_NODATA)) begin
                if (ends) begin
                    if (s.status == pdau_pkg::ST_LO_CONF) begin
                        s.status = pdau_pkg::ST_LO_DONE;
                    end else if (s.status == pdau_pkg::ST_HI_CONF) begin
                        s.status = pdau_pkg::ST_HI_DONE;
                    end else begin
                        s = f_clear(s, pdau_pkg::PCT_ZERO);
                    end
                end else if (s.max >= $signed({1'b0, hi_thr})) begin
                    if (s.conf >= $signed(pdau_pkg::CONF_MIN)) begin
                        s.status = pdau_pkg::ST_HI_CONF;
                    end else if (s.dur == 16'sd1) begin
                        s.status = pdau_pkg::ST_HI_FIRST;
                    end else if (s.status != pdau_pkg::ST_HI_CONF) begin
                        s.status = pdau_pkg::ST_HI_PROV;
                    end
                end else if (s.max >= $signed({1'b0, lo_thr})) begin
                    if (s.conf >= $signed(pdau_pkg::CONF_MIN)) begin
                        s.status = pdau_pkg::ST_LO_CONF;
                    end else if (s.dur == 16'sd1) begin
                        s.status = pdau_pkg::ST_LO_FIRST;
                    end else if (s.status != pdau_pkg::ST_LO_CONF) begin
                        s.status = pdau_pkg::ST_LO_PROV;
                    end
                end else begin
                    s.status = pdau_pkg::ST_NONE;
                end
            end
            s.last = $signed({1'b0, cd});
        end
        return s;
    endfunction

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_date  <= 15'd0;
            r_low_thr   <= 15'd15;
            r_high_thr  <= 15'd50;
            r_quiet_lim <= 15'd15;
        end else if (i_cfg_we) begin
            unique case (pdau_pkg::t_cfg_idx'(i_cfg_idx))
                pdau_pkg::CFG_CUR_DATE:  r_cur_date  <= i_cfg_data;
                pdau_pkg::CFG_LOW_THR:   r_low_thr   <= i_cfg_data;
                pdau_pkg::CFG_HIGH_THR:  r_high_thr  <= i_cfg_data;
                pdau_pkg::CFG_QUIET_LIM: r_quiet_lim <= i_cfg_data;
            endcase
        end
    end

    // handshake
    assign adv = !r_ovld || i_out_ready;

    always_comb begin
        hazard = r_in_v && (r_in.pixel_index == i_in_data.pixel_index);
        for (int k = 0; k <= LAST; k++) begin
            if (r_v[k] && (r_w[k].idx == i_in_data.pixel_index)) begin
                hazard = 1'b1;
            end
        end
    end

    assign o_in_ready = adv && !r_clearing && !hazard;
    assign accept     = i_in_valid && o_in_ready;

    // pipeline next values
    always_comb begin
        n_w[0] = f_pre(r_in, ({1'b0, r_in.pixel_index} < 25'(NUM_PIXELS)), rd_data,
                       r_cur_date, r_low_thr);
        for (int k = 1; k <= LAST; k++) begin
            n_w[k] = r_w[k-1];
        end
        n_w[SB] = f_stage_b(r_w[SB-1], q1, r_cur_date);
        // confidence products
        n_w[SC]     = r_w[SC-1];
        n_w[SC].p1  = 30'(r_w[SC-1].s.conf[14:0]) * 30'(r_w[SC-1].n);
        n_w[SC].p2  = 23'(r_w[SC-1].cac) * 23'(r_w[SC-1].pc2);
        n_w[SC].den = 31'(r_w[SC-1].pc2) * (31'(r_w[SC-1].n) + 31'd1);
        n_w[SD]      = r_w[SD-1];
        n_w[SD].num  = (47'(r_w[SD-1].p1) + 47'(r_w[SD-1].p2)) * 47'(r_w[SD-1].cn2);
        n_w[SD].capd = 46'(r_w[SD-1].den) * 46'(pdau_pkg::CONF_CAP);
        // saturate check ahead of the divider
        n_w[SE]      = r_w[SE-1];
        n_w[SE].over = (r_w[SE-1].num > {1'b0, r_w[SE-1].capd});
        if (n_w[SE].over) begin
            n_w[SE].num = '0;
        end
        n_w[SP] = r_w[SP-1];
        if (r_w[SP-1].upd && r_w[SP-1].pdiv) begin
            n_w[SP].s.pct = {1'b0, q2};
        end
        fin = f_fin(r_w[LAST], q3, r_cur_date, r_low_thr, r_high_thr, r_quiet_lim);
        n_out.out_pixel_index = r_w[LAST].idx;
        n_out.out_status      = fin.status;
        n_out.out_max         = fin.max;
        n_out.out_confidence  = fin.conf;
        n_out.out_start_date  = fin.start;
        n_out.out_count       = fin.count;
        n_out.out_percent     = fin.pct;
        n_out.out_duration    = fin.dur;
        n_out.out_last_obs    = fin.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
            r_v    <= '0;
            r_ovld <= 1'b0;
        end else if (adv) begin
            r_in_v <= accept;
            r_v    <= {r_v[LAST-1:0], r_in_v};
            r_ovld <= r_v[LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_in  <= i_in_data;
            r_w   <= n_w;
            r_out <= n_out;
        end
    end

    // dividers
    pdau_div #(.NW(15), .DW(7), .QW(D1)) u_div_prevno (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (r_w[0].d1num),
        .i_den (r_w[0].d1den),
        .o_quo (q1)
    );

    pdau_div #(.NW(15), .DW(15), .QW(D2)) u_div_pct (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (r_w[SB].d2num),
        .i_den (r_w[SB].d2den),
        .o_quo (q2)
    );

    pdau_div #(.NW(47), .DW(31), .QW(D3)) u_div_conf (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (r_w[SE].num),
        .i_den (r_w[SE].den),
        .o_quo (q3)
    );

    // clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(NUM_PIXELS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    assign wr_en   = r_clearing || (adv && r_v[LAST] && r_w[LAST].ok);
    assign wr_addr = r_clearing ? r_clr_addr : r_w[LAST].idx[AW-1:0];
    assign wr_data = r_clearing ? pdau_pkg::STATE_RST : fin;

    pdau_ram #(.WIDTH($bits(pdau_pkg::t_state)), .DEPTH(NUM_PIXELS)) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (adv),
        .i_raddr (i_in_data.pixel_index[AW-1:0]),
        .o_rdata (rd_data)
    );

    assign o_out_valid = r_ovld;
    assign o_out_data  = r_out;

endmodule
